// ===== rtl/xmt_pkg.sv =====
`default_nettype none

package xmt_pkg;

  localparam int unsigned CharBitsDef = 16;
  localparam int unsigned HintBits    = 5;

  // ASCII codes the lexer reacts to
  localparam logic [7:0] ChrLt    = 8'h3C;
  localparam logic [7:0] ChrSlash = 8'h2F;
  localparam logic [7:0] ChrQmark = 8'h3F;
  localparam logic [7:0] ChrGt    = 8'h3E;
  localparam logic [7:0] ChrEq    = 8'h3D;
  localparam logic [7:0] ChrQuote = 8'h22;
  localparam logic [7:0] ChrUnder = 8'h5F;
  localparam logic [7:0] ChrDot   = 8'h2E;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrLf    = 8'h0A;

  typedef enum logic [HintBits-1:0] {
    HintUnknown     = 5'd0,
    HintStartDecl   = 5'd1,
    HintDecl        = 5'd2,
    HintEndDecl     = 5'd3,
    HintStartOpen   = 5'd4,
    HintOpen        = 5'd5,
    HintEndOpen     = 5'd6,
    HintStartClose  = 5'd7,
    HintClose       = 5'd8,
    HintEndClose    = 5'd9,
    HintStartText   = 5'd10,
    HintText        = 5'd11,
    HintEndText     = 5'd12,
    HintStartAname  = 5'd13,
    HintAname       = 5'd14,
    HintEndAname    = 5'd15,
    HintStartAval   = 5'd16,
    HintAval        = 5'd17,
    HintEndAval     = 5'd18,
    HintEnded       = 5'd19
  } hint_e;

  // character class flags handed from the classifier to the lexer
  typedef struct packed {
    logic is_name;
    logic is_space;   // NUL, space, CR, tab, LF
    logic is_blank;   // plain space only
    logic is_lt;
    logic is_slash;
    logic is_qmark;
    logic is_gt;
    logic is_eq;
    logic is_quote;
  } char_class_t;

endpackage

`default_nettype wire

// ===== rtl/xmt_if.sv =====
`default_nettype none

interface xmt_in_if #(
  parameter int unsigned CharBits = xmt_pkg::CharBitsDef
);
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] char_code;
  logic                end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface xmt_out_if;
  logic                          valid;
  logic                          ready;
  logic [xmt_pkg::HintBits-1:0]  hint;
  logic                          is_name_char;
  logic                          is_last;

  modport source (output valid, output hint, output is_name_char, output is_last, input ready);
  modport sink   (input valid, input hint, input is_name_char, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/xml_markup_tokenizer.sv =====
`default_nettype none

// Markup tokenizer: takes one text character per transaction and returns, for
// each one, the lexer phase after that character, whether it is a name
// character, and an echo of the end-of-text flag. A character is captured in
// an input register, classified and run through the next-state table
// combinationally, and the result lands in an output register. A character is
// accepted every cycle, as the next-state logic feeds the lexer state register
// directly; only a stalled output register holds the input back. A malformed
// sequence or the last character sticks the lexer in the Ended phase until
// reset. Only the low CHAR_BITS bits of a character are looked at, and any
// code above 8 bits belongs to no character class.
module xml_markup_tokenizer #(
  parameter int unsigned CHAR_BITS = xmt_pkg::CharBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  xmt_in_if.sink            in_i,
  xmt_out_if.source         out_o
);

  logic                 s1_valid_q;
  logic [CHAR_BITS-1:0] s1_char_q;
  logic                 s1_last_q;

  logic                 out_valid_q;
  xmt_pkg::hint_e       hint_q;
  logic                 name_q;
  logic                 last_q;

  logic                 out_free;
  logic                 advance;
  logic                 in_take;

  xmt_pkg::char_class_t cls;
  xmt_pkg::hint_e       hint_next;

  assign out_free    = !out_valid_q || out_o.ready;
  assign advance     = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_take     = in_i.valid && in_i.ready;

  xmt_classify #(
    .CharBits (CHAR_BITS)
  ) u_classify (
    .char_i (s1_char_q),
    .cls_o  (cls)
  );

  xmt_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cls_i  (cls),
    .last_i (s1_last_q),
    .hint_o (hint_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (out_free)   out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= in_i.char_code;
      s1_last_q <= in_i.end_of_text;
    end
    if (advance) begin
      hint_q <= hint_next;
      name_q <= cls.is_name;
      last_q <= s1_last_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.hint         = hint_q;
  assign out_o.is_name_char = name_q;
  assign out_o.is_last      = last_q;

  // a captured character waits while the output register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |=> s1_valid_q)
    else $error("xml_markup_tokenizer: pending character dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> out_valid_q)
    else $error("xml_markup_tokenizer: result lost on advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.is_last) |-> (out_o.hint == xmt_pkg::HintEnded))
    else $error("xml_markup_tokenizer: last character without Ended phase");

endmodule

`default_nettype wire

// ===== rtl/xmt_classify.sv =====
`default_nettype none

module xmt_classify #(
  parameter int unsigned CharBits = xmt_pkg::CharBitsDef
) (
  input  logic [CharBits-1:0] char_i,
  output xmt_pkg::char_class_t cls_o
);

  logic       hi_zero;
  logic [7:0] lo;

  // anything above the byte range is no markup character at all
  assign hi_zero = ((char_i >> 8) == '0);
  assign lo      = char_i[7:0];

  always_comb begin
    cls_o.is_name  = hi_zero && ((lo >= 8'h61 && lo <= 8'h7A) ||
                                 (lo >= 8'h41 && lo <= 8'h5A) ||
                                 (lo >= 8'h30 && lo <= 8'h39) ||
                                 lo == xmt_pkg::ChrUnder || lo == xmt_pkg::ChrDot);
    cls_o.is_space = hi_zero && (lo == 8'h00 || lo == xmt_pkg::ChrSpace ||
                                 lo == xmt_pkg::ChrCr || lo == xmt_pkg::ChrTab ||
                                 lo == xmt_pkg::ChrLf);
    cls_o.is_blank = hi_zero && (lo == xmt_pkg::ChrSpace);
    cls_o.is_lt    = hi_zero && (lo == xmt_pkg::ChrLt);
    cls_o.is_slash = hi_zero && (lo == xmt_pkg::ChrSlash);
    cls_o.is_qmark = hi_zero && (lo == xmt_pkg::ChrQmark);
    cls_o.is_gt    = hi_zero && (lo == xmt_pkg::ChrGt);
    cls_o.is_eq    = hi_zero && (lo == xmt_pkg::ChrEq);
    cls_o.is_quote = hi_zero && (lo == xmt_pkg::ChrQuote);
  end

endmodule

`default_nettype wire

// ===== rtl/xmt_lexer.sv =====
`default_nettype none

module xmt_lexer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  xmt_pkg::char_class_t cls_i,
  input  logic                 last_i,
  output xmt_pkg::hint_e       hint_o
);

  xmt_pkg::hint_e state_q, state_d;
  logic           qwait_q, qwait_d;

  always_comb begin
    qwait_d = qwait_q;
    state_d = state_q;
    if (qwait_q) begin
      qwait_d = 1'b0;
      state_d = cls_i.is_gt ? xmt_pkg::HintEndDecl : xmt_pkg::HintEnded;
    end else begin
      case (state_q)
        xmt_pkg::HintUnknown, xmt_pkg::HintEndDecl, xmt_pkg::HintEndClose: begin
          if (!cls_i.is_space) begin
            state_d = cls_i.is_lt ? xmt_pkg::HintStartOpen : xmt_pkg::HintEnded;
          end
        end
        xmt_pkg::HintEndOpen: begin
          if (!cls_i.is_space) begin
            state_d = cls_i.is_lt ? xmt_pkg::HintStartOpen : xmt_pkg::HintStartText;
          end
        end
        xmt_pkg::HintStartText, xmt_pkg::HintText: begin
          state_d = cls_i.is_lt ? xmt_pkg::HintEndText : xmt_pkg::HintText;
        end
        xmt_pkg::HintStartOpen, xmt_pkg::HintEndText: begin
          if (cls_i.is_slash)      state_d = xmt_pkg::HintStartClose;
          else if (cls_i.is_qmark) state_d = xmt_pkg::HintStartDecl;
          else if (cls_i.is_name)  state_d = xmt_pkg::HintOpen;
          else                     state_d = xmt_pkg::HintEnded;
        end
        xmt_pkg::HintStartDecl: begin
          state_d = cls_i.is_name ? xmt_pkg::HintDecl : xmt_pkg::HintEnded;
        end
        xmt_pkg::HintStartClose: begin
          state_d = cls_i.is_name ? xmt_pkg::HintClose : xmt_pkg::HintEnded;
        end
        xmt_pkg::HintDecl: begin
          if (!cls_i.is_name) begin
            if (cls_i.is_blank)      state_d = xmt_pkg::HintStartAname;
            else if (cls_i.is_qmark) qwait_d = 1'b1;
          end
        end
        xmt_pkg::HintOpen: begin
          if (!cls_i.is_name) begin
            if (cls_i.is_blank)   state_d = xmt_pkg::HintStartAname;
            else if (cls_i.is_gt) state_d = xmt_pkg::HintEndOpen;
          end
        end
        xmt_pkg::HintClose: begin
          if (!cls_i.is_name && cls_i.is_gt) state_d = xmt_pkg::HintEndClose;
        end
        xmt_pkg::HintStartAname, xmt_pkg::HintAname: begin
          if (cls_i.is_name)    state_d = xmt_pkg::HintAname;
          else if (cls_i.is_eq) state_d = xmt_pkg::HintEndAname;
          else                  state_d = xmt_pkg::HintEnded;
        end
        xmt_pkg::HintEndAname: begin
          if (cls_i.is_quote)   state_d = xmt_pkg::HintStartAval;
          else if (cls_i.is_gt) state_d = xmt_pkg::HintEndOpen;
        end
        xmt_pkg::HintStartAval, xmt_pkg::HintAval: begin
          if (cls_i.is_name)       state_d = xmt_pkg::HintAval;
          else if (cls_i.is_quote) state_d = xmt_pkg::HintEndAval;
          else if (cls_i.is_gt)    state_d = xmt_pkg::HintEnded;
        end
        xmt_pkg::HintEndAval: begin
          if (cls_i.is_gt)         state_d = xmt_pkg::HintEndOpen;
          else if (cls_i.is_qmark) qwait_d = 1'b1;
          else if (cls_i.is_blank) state_d = xmt_pkg::HintStartAname;
          else                     state_d = xmt_pkg::HintEnded;
        end
        default: begin
          state_d = xmt_pkg::HintEnded;
        end
      endcase
    end
    if (last_i) state_d = xmt_pkg::HintEnded;
    if (state_d == xmt_pkg::HintEnded) qwait_d = 1'b0;
  end

  assign hint_o = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xmt_pkg::HintUnknown;
      qwait_q <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      qwait_q <= qwait_d;
    end
  end

  // a pending '?' only arises in a declaration or after an attribute value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qwait_q |-> (state_q == xmt_pkg::HintDecl || state_q == xmt_pkg::HintEndAval))
    else $error("xmt_lexer: pending '?' in unexpected phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == xmt_pkg::HintEnded) |=> (state_q == xmt_pkg::HintEnded))
    else $error("xmt_lexer: left the Ended phase without reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && qwait_q) |=>
      (state_q == xmt_pkg::HintEndDecl || state_q == xmt_pkg::HintEnded) && !qwait_q)
    else $error("xmt_lexer: '?' not resolved by the following character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (state_q == xmt_pkg::HintEnded && !qwait_q))
    else $error("xmt_lexer: last character did not end the text");

endmodule

`default_nettype wire
